>>> src/nlr_pkg.sv
`default_nettype none
package nlr_pkg;

  // Longest count the length field can carry
  localparam int unsigned MAX_LEN = 255;
  localparam int unsigned LEN_CAP = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam logic [7:0]  LEN_CAP_V = 8'(LEN_CAP);

  // Decoupling queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ZERO = 3'd1,
    PH_NEED = 3'd2,
    PH_INT  = 3'd3,
    PH_DOT  = 3'd4,
    PH_FRAC = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    RX_BIN = 2'd0,
    RX_OCT = 2'd1,
    RX_DEC = 2'd2,
    RX_HEX = 2'd3
  } radix_e;

  typedef enum logic [2:0] {
    BASE_NONE = 3'd0,
    BASE_BIN  = 3'd1,
    BASE_OCT  = 3'd2,
    BASE_DEC  = 3'd3,
    BASE_HEX  = 3'd4
  } base_e;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_O     = 8'h6f;  // 'o'
  localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'

  // Character class of one beat, as the back end consumes it
  typedef struct packed {
    logic start;
    logic is_zero;
    logic is_bin;
    logic is_oct;
    logic is_dec;
    logic is_hex;
    logic is_x;
    logic is_b;
    logic is_o;
    logic is_dot;
  } cls_t;

endpackage
`default_nettype wire

>>> src/numeric_literal_recognizer_unit.sv
// Numeric literal recognizer. Feed text one character per beat; set
// start_req_i on the first character of each candidate token. A literal is
// decimal digits, or a lowercase 0x/0b/0o prefix and hex/binary/octal digits,
// with at most one '.' that must be followed by a digit. The character that
// ends the literal yields one result beat: length (prefix included, 0 on
// reject), base_code (0 none, 1 bin, 2 oct, 3 dec, 4 hex), fractional and
// saturated (length stuck at 255). Characters outside a candidate give no
// result; a new start abandons an open candidate silently. Throughput is one
// character per clock while the queue has room, set by the phase update in the
// back end; the character that ends a literal passes through the 4-entry
// queue and one output register, and its result beat waits while the result
// side stalls. No reset sweep; the block accepts input right after reset.
`default_nettype none
module numeric_literal_recognizer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       start_req_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      length_o,
  output logic [2:0]      base_code_o,
  output logic            fractional_o,
  output logic            saturated_o
);
  import nlr_pkg::*;

  // front -> queue
  logic q_push;
  cls_t q_in;
  logic q_full;
  // queue -> back
  logic q_pop;
  cls_t q_out;
  logic q_empty;

  // Front end: classify each character beat, push it into the queue
  nlr_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  // Short queue so the input side keeps flowing while results back up
  nlr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back end: token state machine and result register
  nlr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .length_o     (length_o),
    .base_code_o  (base_code_o),
    .fractional_o (fractional_o),
    .saturated_o  (saturated_o)
  );

endmodule
`default_nettype wire

>>> src/nlr_front.sv
`default_nettype none
module nlr_front (
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   ch_i,
  input  wire logic         start_req_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output nlr_pkg::cls_t     q_entry_o
);
  import nlr_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.start   = start_req_i;
    q_entry_o.is_zero = (ch_i == CH_ZERO);
    q_entry_o.is_bin  = (ch_i == CH_ZERO) || (ch_i == CH_ONE);
    q_entry_o.is_oct  = (ch_i >= CH_ZERO) && (ch_i <= CH_SEVEN);
    q_entry_o.is_dec  = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    q_entry_o.is_hex  = ((ch_i >= CH_ZERO) && (ch_i <= CH_NINE)) ||
                        ((ch_i >= CH_LA) && (ch_i <= CH_LF)) ||
                        ((ch_i >= CH_UA) && (ch_i <= CH_UF));
    q_entry_o.is_x    = (ch_i == CH_X);
    q_entry_o.is_b    = (ch_i == CH_B);
    q_entry_o.is_o    = (ch_i == CH_O);
    q_entry_o.is_dot  = (ch_i == CH_DOT);
  end

endmodule
`default_nettype wire

>>> src/nlr_queue.sv
`default_nettype none
module nlr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire nlr_pkg::cls_t push_data_i,
  input  wire logic          pop_i,
  output nlr_pkg::cls_t      pop_data_o,
  output logic               full_o,
  output logic               empty_o
);
  import nlr_pkg::*;

  cls_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> src/nlr_back.sv
`default_nettype none
module nlr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire nlr_pkg::cls_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         length_o,
  output logic [2:0]         base_code_o,
  output logic               fractional_o,
  output logic               saturated_o
);
  import nlr_pkg::*;

  phase_e     phase_q, phase_d;
  radix_e     radix_q, radix_d;
  logic [7:0] count_q, count_d;
  logic       dot_q, dot_d;
  logic       stuck_q, stuck_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] len_q, len_d;
  logic [2:0] base_q, base_d;
  logic       frac_q, frac_d;
  logic       sat_q, sat_d;

  logic       out_free;
  logic       emit;
  logic       accept;
  logic       digit;
  logic [7:0] bump_cnt;
  logic       bump_stk;
  cls_t       c;

  assign c        = q_data_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = !q_empty_i && out_free;

  assign bump_cnt = (count_q < LEN_CAP_V) ? count_q + 8'd1 : count_q;
  assign bump_stk = stuck_q || (count_q >= LEN_CAP_V);

  always_comb begin
    case (radix_q)
      RX_BIN:  digit = c.is_bin;
      RX_OCT:  digit = c.is_oct;
      RX_DEC:  digit = c.is_dec;
      RX_HEX:  digit = c.is_hex;
      default: digit = c.is_hex;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    count_d = count_q;
    dot_d   = dot_q;
    stuck_d = stuck_q;
    emit    = 1'b0;
    accept  = 1'b0;

    if (q_pop_o) begin
      if (c.start) begin
        count_d = 8'd1;
        stuck_d = 1'b0;
        dot_d   = 1'b0;
        radix_d = RX_DEC;
        if (c.is_zero) begin
          phase_d = PH_ZERO;
        end else if (c.is_dec) begin
          phase_d = PH_INT;
        end else begin
          radix_d = RX_BIN;
          phase_d = PH_IDLE;
          emit    = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_ZERO: begin
            if (c.is_x || c.is_b || c.is_o) begin
              radix_d = c.is_x ? RX_HEX : (c.is_b ? RX_BIN : RX_OCT);
              count_d = bump_cnt;
              stuck_d = bump_stk;
              phase_d = PH_NEED;
            end else if (digit) begin
              count_d = bump_cnt;
              stuck_d = bump_stk;
              phase_d = PH_INT;
            end else if (c.is_dot) begin
              dot_d   = 1'b1;
              count_d = bump_cnt;
              stuck_d = bump_stk;
              phase_d = PH_DOT;
            end else begin
              emit    = 1'b1;
              accept  = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          PH_NEED, PH_DOT: begin
            if (digit) begin
              count_d = bump_cnt;
              stuck_d = bump_stk;
              phase_d = (phase_q == PH_NEED) ? PH_INT : PH_FRAC;
            end else begin
              emit    = 1'b1;
              phase_d = PH_IDLE;
              dot_d   = 1'b0;
            end
          end
          PH_INT: begin
            if (digit) begin
              count_d = bump_cnt;
              stuck_d = bump_stk;
            end else if (c.is_dot) begin
              dot_d   = 1'b1;
              count_d = bump_cnt;
              stuck_d = bump_stk;
              phase_d = PH_DOT;
            end else begin
              emit    = 1'b1;
              accept  = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          PH_FRAC: begin
            if (digit) begin
              count_d = bump_cnt;
              stuck_d = bump_stk;
            end else begin
              emit    = 1'b1;
              accept  = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Output register: a new result loads as the old one leaves
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    len_d       = len_q;
    base_d      = base_q;
    frac_d      = frac_q;
    sat_d       = sat_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (accept) begin
        len_d  = count_q;
        base_d = 3'(radix_q) + 3'd1;
        frac_d = dot_q;
        sat_d  = stuck_q;
      end else begin
        len_d  = 8'd0;
        base_d = BASE_NONE;
        frac_d = 1'b0;
        sat_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      radix_q     <= RX_BIN;
      count_q     <= '0;
      dot_q       <= 1'b0;
      stuck_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      radix_q     <= radix_d;
      count_q     <= count_d;
      dot_q       <= dot_d;
      stuck_q     <= stuck_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    base_q <= base_d;
    frac_q <= frac_d;
    sat_q  <= sat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign length_o     = len_q;
  assign base_code_o  = base_q;
  assign fractional_o = frac_q;
  assign saturated_o  = sat_q;

endmodule
`default_nettype wire

>>> tb/testbench.sv
module testbench;
  import nlr_pkg::*;

  localparam int LONG_HOLD     = 300;      // receiver hold-off used to fill the block
  localparam int CHAR_TARGET   = 1700;
  localparam int QUIET_FROM    = 1450;     // no idling on either side after this many chars
  localparam int HOLD_AT       = 700;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_G     = 8'h67;

  // One expected result beat
  typedef struct packed {
    logic [7:0] length;
    base_e      base;
    logic       fractional;
    logic       saturated;
  } lit_result_t;

  // Tracks the literal being scanned and the result beats still owed by the block
  class literal_scoreboard;
    phase_e      phase;
    radix_e      radix;
    logic [7:0]  count;
    logic        dot_seen;
    logic        stuck;
    lit_result_t pending[$];
    int          errors;
    int          checked;
    int          rejects;
    int          saturations;

    function new();
      phase       = PH_IDLE;
      radix       = RX_BIN;
      count       = '0;
      dot_seen    = 1'b0;
      stuck       = 1'b0;
      errors      = 0;
      checked     = 0;
      rejects     = 0;
      saturations = 0;
    endfunction

    function bit is_digit(radix_e r, logic [7:0] c);
      case (r)
        RX_BIN:  return c == CH_ZERO || c == CH_ONE;
        RX_OCT:  return c >= CH_ZERO && c <= CH_SEVEN;
        RX_DEC:  return c >= CH_ZERO && c <= CH_NINE;
        default: return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
                        (c >= CH_UA && c <= CH_UF);
      endcase
    endfunction

    function void bump();
      if (count < LEN_CAP_V) count++;
      else stuck = 1'b1;
    endfunction

    function void owe_reject();
      pending.push_back('{length: 8'd0, base: BASE_NONE, fractional: 1'b0, saturated: 1'b0});
      rejects++;
      phase    = PH_IDLE;
      dot_seen = 1'b0;
    endfunction

    function void owe_accept();
      base_e b;
      case (radix)
        RX_BIN:  b = BASE_BIN;
        RX_OCT:  b = BASE_OCT;
        RX_DEC:  b = BASE_DEC;
        default: b = BASE_HEX;
      endcase
      pending.push_back('{length: count, base: b, fractional: dot_seen, saturated: stuck});
      if (stuck) saturations++;
      phase = PH_IDLE;
    endfunction

    // Integer part: another digit, the one dot, or the end of the literal
    function void scan_int(logic [7:0] c);
      if (is_digit(radix, c)) begin
        bump();
      end else if (c == CH_DOT) begin
        dot_seen = 1'b1;
        bump();
        phase = PH_DOT;
      end else begin
        owe_accept();
      end
    endfunction

    function void note_input(logic [7:0] c, logic s);
      if (s) begin
        count    = '0;
        stuck    = 1'b0;
        dot_seen = 1'b0;
        radix    = RX_DEC;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          bump();
          if (c == CH_ZERO) phase = PH_ZERO;
          else phase = PH_INT;
        end else begin
          radix = RX_BIN;
          owe_reject();
        end
        return;
      end
      case (phase)
        PH_ZERO: begin
          if (c == CH_X || c == CH_B || c == CH_O) begin
            if (c == CH_X) radix = RX_HEX;
            else if (c == CH_B) radix = RX_BIN;
            else radix = RX_OCT;
            bump();
            phase = PH_NEED;
          end else begin
            phase = PH_INT;   // lone zero is a decimal digit
            scan_int(c);
          end
        end
        PH_NEED: begin
          if (is_digit(radix, c)) begin
            bump();
            phase = PH_INT;
          end else begin
            owe_reject();
          end
        end
        PH_INT: scan_int(c);
        PH_DOT: begin
          if (is_digit(radix, c)) begin
            bump();
            phase = PH_FRAC;
          end else begin
            owe_reject();
          end
        end
        PH_FRAC: begin
          if (is_digit(radix, c)) bump();
          else owe_accept();
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH %s", what);
    endtask

    task check_result(logic [7:0] len, logic [2:0] bc, logic frac, logic sat);
      lit_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat with none owed: len=%0d base=%0d frac=%0b sat=%0b",
                         len, bc, frac, sat));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (len !== want.length)
        report($sformatf("beat %0d length %0d, want %0d", checked, len, want.length));
      if (bc !== want.base)
        report($sformatf("beat %0d base_code %0d, want %0d", checked, bc, want.base));
      if (frac !== want.fractional)
        report($sformatf("beat %0d fractional %0b, want %0b", checked, frac, want.fractional));
      if (sat !== want.saturated)
        report($sformatf("beat %0d saturated %0b, want %0b", checked, sat, want.saturated));
    endtask

    task final_check();
      if (pending.size() != 0)
        report($sformatf("%0d result beats never arrived", pending.size()));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] ch_i;
  logic       start_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] length_o;
  logic [2:0] base_code_o;
  logic       fractional_o;
  logic       saturated_o;

  literal_scoreboard sb = new();

  logic [7:0] token_chars[$];
  int         chars_sent   = 0;
  int         tokens_sent  = 0;
  int         stall_cycles = 0;
  int         idle_odds    = 0;
  bit         idle_en      = 1'b1;
  bit         long_hold    = 1'b0;

  numeric_literal_recognizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .length_o     (length_o),
    .base_code_o  (base_code_o),
    .fractional_o (fractional_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Both channels sampled on the rising edge; inputs only move on the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(ch_i, start_req_i);
    if (rst_ni && in_valid_i && in_stall_o) stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(length_o, base_code_o, fractional_o, saturated_o);
  end

  // Result side: free-running stretches, random stall bursts, and one long hold-off
  // that backs the block up into its input.
  initial begin : result_sink
    int span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        span = LONG_HOLD;
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        span = $urandom_range(1, 15);
      end else begin
        out_stall_i <= 1'b0;
        span = $urandom_range(1, 30);
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  // Offer one character beat; called and returns on a falling edge.
  // The payload holds still for as long as the block stalls it.
  task automatic send_char(input logic [7:0] c, input logic s);
    if (idle_en && $urandom_range(0, 9) < idle_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ch_i        <= c;
    start_req_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // First character opens the candidate, the rest follow it
  task automatic send_token();
    foreach (token_chars[i]) send_char(token_chars[i], i == 0);
    tokens_sent++;
  endtask

  function automatic logic [7:0] pick_digit(radix_e r);
    int k;
    case (r)
      RX_BIN:  return CH_ZERO + 8'($urandom_range(0, 1));
      RX_OCT:  return CH_ZERO + 8'($urandom_range(0, 7));
      RX_DEC:  return CH_ZERO + 8'($urandom_range(0, 9));
      default: begin
        k = $urandom_range(0, 21);
        if (k < 10) return CH_ZERO + 8'(k);
        if (k < 16) return CH_LA + 8'(k - 10);
        return CH_UA + 8'(k - 16);
      end
    endcase
  endfunction

  // Mostly well-formed literals with random content; some bent out of shape
  // (stray bytes, empty prefix, dot with no fraction, missing terminator).
  function automatic void make_token();
    radix_e r;
    int     ndig;
    int     nfrac;
    token_chars.delete();
    r = radix_e'($urandom_range(0, 3));
    if (r == RX_DEC) begin
      if ($urandom_range(0, 3) == 0) token_chars.push_back(CH_ZERO);
    end else begin
      token_chars.push_back(CH_ZERO);
      if ($urandom_range(0, 19) == 0) token_chars.push_back(8'($urandom_range(0, 255)));
      else if (r == RX_HEX) token_chars.push_back(CH_X);
      else if (r == RX_BIN) token_chars.push_back(CH_B);
      else token_chars.push_back(CH_O);
    end
    // rare long literal to run the length count into its cap
    if ($urandom_range(0, 79) == 0) ndig = $urandom_range(250, 270);
    else ndig = $urandom_range(0, 6);
    if (r == RX_DEC && token_chars.size() == 0 && ndig == 0) ndig = 1;
    repeat (ndig) begin
      if ($urandom_range(0, 11) == 0) token_chars.push_back(8'($urandom_range(0, 255)));
      else token_chars.push_back(pick_digit(r));
    end
    if ($urandom_range(0, 2) == 0) begin
      token_chars.push_back(CH_DOT);
      nfrac = $urandom_range(0, 4);
      repeat (nfrac) token_chars.push_back(pick_digit(r));
    end
    if ($urandom_range(0, 4) != 0) token_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin : stimulus
    bit hold_issued;
    int drain;
    hold_issued = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ch_i        = '0;
    start_req_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every base, fraction, empty prefix, dangling dot, bad first char,
    // ignored idle char, and a start that abandons an open literal.
    token_chars = '{CH_ZERO, CH_X, CH_UF, CH_DOT, CH_LA, CH_G};
    send_token();
    token_chars = '{CH_ZERO, CH_B, CH_ONE, CH_ONE + 8'd1};
    send_token();
    token_chars = '{CH_ZERO, CH_O, CH_SEVEN, CH_NINE};
    send_token();
    token_chars = '{CH_ZERO, CH_B, CH_DOT};
    send_token();
    token_chars = '{CH_NINE, CH_DOT, CH_SPACE};
    send_token();
    token_chars = '{CH_ZERO, CH_DOT, CH_ONE, CH_NUL};
    send_token();
    token_chars = '{8'hFF};
    send_token();
    send_char(CH_NUL, 1'b0);
    token_chars = '{CH_ZERO + 8'd5};
    send_token();
    token_chars = '{CH_ONE, CH_NUL};
    send_token();

    // Random traffic
    while (chars_sent < CHAR_TARGET) begin
      if (!hold_issued && chars_sent >= HOLD_AT) begin
        long_hold   = 1'b1;
        hold_issued = 1'b1;
      end
      if (chars_sent >= QUIET_FROM) idle_en = 1'b0;
      idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) begin
        // raw noise, start flag at random
        repeat ($urandom_range(1, 4))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        make_token();
        send_token();
      end
    end
    in_valid_i <= 1'b0;

    drain = 0;
    while (sb.pending.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    sb.final_check();

    $display("Sent %0d characters in %0d candidates; checked %0d result beats (%0d rejects, %0d saturated).",
             chars_sent, tokens_sent, sb.checked, sb.rejects, sb.saturations);
    $display("Input held off by the block on %0d cycles; %0d mismatches.",
             stall_cycles, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS numeric_literal_recognizer_unit");
    end else begin
      $display("FAIL numeric_literal_recognizer_unit");
    end
    $finish;
  end

  // Far beyond the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("Timed out with %0d result beats owed.", sb.pending.size());
    $display("FAIL numeric_literal_recognizer_unit");
    $finish;
  end

endmodule
